// ----- design/necir_pkg.sv -----
`timescale 1ns / 1ps
// necir_pkg: shared constants and helpers for the nec ir frame decoder
// holds timing windows, register map and bit reversal; no dependencies

package necir_pkg;

  localparam int unsigned IntervalW = 16;
  localparam int unsigned FrameW    = 32;
  localparam int unsigned CountW    = 16;
  localparam int unsigned BitPosW   = 6;    // holds 0..FrameW
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  typedef logic [IntervalW-1:0] interval_t;
  typedef logic [FrameW-1:0]    frame_t;
  typedef logic [CountW-1:0]    count_t;
  typedef logic [BitPosW-1:0]   bit_pos_t;
  typedef logic [ApbAddrW-1:0]  apb_addr_t;
  typedef logic [ApbDataW-1:0]  apb_data_t;

  // register map
  localparam apb_addr_t REG_GAP_LIMIT = 3'd0;
  localparam interval_t GAP_LIMIT_RST = 16'd10000;

  // open timing windows, lo < d < hi, in microseconds
  localparam interval_t LEAD_LO    = 16'd8750;
  localparam interval_t LEAD_HI    = 16'd9250;
  localparam interval_t FSPACE_LO  = 16'd4250;
  localparam interval_t FSPACE_HI  = 16'd4750;
  localparam interval_t RSPACE_LO  = 16'd2000;
  localparam interval_t RSPACE_HI  = 16'd2500;
  localparam interval_t BURST_LO   = 16'd320;
  localparam interval_t BURST_HI   = 16'd812;
  localparam interval_t ONE_LO     = 16'd1437;
  localparam interval_t ONE_HI     = 16'd1937;
  localparam interval_t ZERO_LO    = 16'd312;
  localparam interval_t ZERO_HI    = 16'd812;

  localparam bit_pos_t  FRAME_BITS = bit_pos_t'(FrameW);
  localparam count_t    COUNT_MAX  = '1;

  localparam logic EVT_FULL   = 1'b0;
  localparam logic EVT_REPEAT = 1'b1;

  function automatic logic in_window(input interval_t d, input interval_t lo,
                                     input interval_t hi);
    in_window = (d > lo) && (d < hi);
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    rev8 = r;
  endfunction

endpackage

// ----- design/nec_ir_frame_decoder_core.sv -----
`timescale 1ns / 1ps
// nec ir frame decoder: an accepted item goes through the input register and the decode step into the result register
// throughput one item per cycle; the single decode stage advances whenever the
// result register is empty or being taken, so a stalled result holds one item
// synchronous active-low reset: phase to lead burst wait, bit count, shift word,
// frame word, valid mark and repeat count to zero, gap limit to 10000 us
// depends on necir_pkg

module nec_ir_frame_decoder_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // interval items from edge capture
  input  logic                         in_valid,
  output logic                         in_stall,
  input  necir_pkg::interval_t         in_interval_us,
  // decoded events
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_event_kind,
  output necir_pkg::frame_t            out_frame_word,
  output logic [7:0]                   out_address_byte,
  output logic [7:0]                   out_command_byte,
  output necir_pkg::count_t            out_repeat_count,
  // apb-style configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  necir_pkg::apb_addr_t         paddr,
  input  necir_pkg::apb_data_t         pwdata,
  output necir_pkg::apb_data_t         prdata,
  output logic                         pready
);

  import necir_pkg::*;

  // decoder phases
  localparam logic [2:0] PH_LEAD     = 3'd0;
  localparam logic [2:0] PH_SPACE    = 3'd1;
  localparam logic [2:0] PH_BITBURST = 3'd2;
  localparam logic [2:0] PH_BITSPACE = 3'd3;
  localparam logic [2:0] PH_REPBURST = 3'd4;
  localparam logic [2:0] PH_END_FULL = 3'd5;
  localparam logic [2:0] PH_END_REP  = 3'd6;
  localparam logic [2:0] PH_ERROR    = 3'd7;

  // configuration
  interval_t gap_limit_r;
  logic      cfg_wr;

  // input register
  logic      s1_valid_r;
  interval_t s1_interval_r;

  // decoder state
  logic [2:0] phase_r, phase_nxt;
  bit_pos_t   bit_pos_r, bit_pos_nxt;
  frame_t     shift_r, shift_nxt;
  frame_t     frame_r, frame_nxt;
  logic       valid_mark_r, valid_mark_nxt;
  count_t     rep_cnt_r, rep_cnt_nxt;

  // result register
  logic       out_valid_r;
  logic       out_kind_r;
  frame_t     out_frame_r;
  logic [7:0] out_addr_r;
  logic [7:0] out_cmd_r;
  count_t     out_cnt_r;

  logic advance;
  logic emit;
  logic emit_kind;

  // ------------------------------------------------------------------
  // configuration port, always ready, one register
  // ------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr == REG_GAP_LIMIT) begin
      prdata = apb_data_t'(gap_limit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= GAP_LIMIT_RST;
    end else if (cfg_wr && (paddr == REG_GAP_LIMIT)) begin
      gap_limit_r <= pwdata[IntervalW-1:0];
    end
  end

  // ------------------------------------------------------------------
  // handshake: the decode stage moves on when the result slot is free or
  // being emptied this cycle; the input register refills in the same cycle
  // ------------------------------------------------------------------
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_interval_r <= in_interval_us;
    end
  end

  // ------------------------------------------------------------------
  // decode step for the item held in the input register
  // ------------------------------------------------------------------
  always_comb begin
    phase_nxt      = phase_r;
    bit_pos_nxt    = bit_pos_r;
    shift_nxt      = shift_r;
    frame_nxt      = frame_r;
    valid_mark_nxt = valid_mark_r;
    rep_cnt_nxt    = rep_cnt_r;
    emit           = 1'b0;
    emit_kind      = EVT_FULL;

    if (s1_interval_r > gap_limit_r) begin
      // long silence: start over, keep the last frame for repeats
      phase_nxt = PH_LEAD;
    end else begin
      unique case (phase_r)
        PH_LEAD: begin
          if (in_window(s1_interval_r, LEAD_LO, LEAD_HI)) begin
            phase_nxt = PH_SPACE;
          end else begin
            phase_nxt      = PH_ERROR;
            valid_mark_nxt = 1'b0;
          end
        end
        PH_SPACE: begin
          if (in_window(s1_interval_r, FSPACE_LO, FSPACE_HI)) begin
            phase_nxt   = PH_BITBURST;
            bit_pos_nxt = '0;
            shift_nxt   = '0;
            rep_cnt_nxt = '0;
          end else if (in_window(s1_interval_r, RSPACE_LO, RSPACE_HI) && valid_mark_r) begin
            phase_nxt = PH_REPBURST;
          end else begin
            phase_nxt      = PH_ERROR;
            valid_mark_nxt = 1'b0;
          end
        end
        PH_BITBURST: begin
          if (!in_window(s1_interval_r, BURST_LO, BURST_HI)) begin
            phase_nxt      = PH_ERROR;
            valid_mark_nxt = 1'b0;
          end else if (bit_pos_r >= FRAME_BITS) begin
            // closing burst of a full frame
            phase_nxt      = PH_END_FULL;
            frame_nxt      = shift_r;
            valid_mark_nxt = 1'b1;
            emit           = 1'b1;
            emit_kind      = EVT_FULL;
          end else begin
            phase_nxt = PH_BITSPACE;
          end
        end
        PH_BITSPACE: begin
          if (in_window(s1_interval_r, ONE_LO, ONE_HI)) begin
            // msb first: bit n of the frame lands at position 31 - n
            if (bit_pos_r < FRAME_BITS) begin
              shift_nxt[~bit_pos_r[BitPosW-2:0]] = 1'b1;
            end
            bit_pos_nxt = bit_pos_r + bit_pos_t'(1);
            phase_nxt   = PH_BITBURST;
          end else if (in_window(s1_interval_r, ZERO_LO, ZERO_HI)) begin
            bit_pos_nxt = bit_pos_r + bit_pos_t'(1);
            phase_nxt   = PH_BITBURST;
          end else begin
            phase_nxt      = PH_ERROR;
            valid_mark_nxt = 1'b0;
          end
        end
        PH_REPBURST: begin
          if (!in_window(s1_interval_r, BURST_LO, BURST_HI)) begin
            phase_nxt      = PH_ERROR;
            valid_mark_nxt = 1'b0;
          end else begin
            phase_nxt = PH_END_REP;
            if (rep_cnt_r != COUNT_MAX) begin
              rep_cnt_nxt = rep_cnt_r + count_t'(1);
            end
            emit      = 1'b1;
            emit_kind = EVT_REPEAT;
          end
        end
        PH_END_FULL, PH_END_REP, PH_ERROR: begin
          // anything but a gap after a finished frame is an error
          phase_nxt      = PH_ERROR;
          valid_mark_nxt = 1'b0;
        end
        default: begin
          phase_nxt      = PH_ERROR;
          valid_mark_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEAD;
      bit_pos_r    <= '0;
      shift_r      <= '0;
      frame_r      <= '0;
      valid_mark_r <= 1'b0;
      rep_cnt_r    <= '0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      bit_pos_r    <= bit_pos_nxt;
      shift_r      <= shift_nxt;
      frame_r      <= frame_nxt;
      valid_mark_r <= valid_mark_nxt;
      rep_cnt_r    <= rep_cnt_nxt;
    end
  end

  // ------------------------------------------------------------------
  // result register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_kind_r  <= emit_kind;
      out_frame_r <= frame_nxt;
      out_addr_r  <= rev8(frame_nxt[31:24]);
      out_cmd_r   <= rev8(frame_nxt[15:8]);
      out_cnt_r   <= rep_cnt_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_kind_r;
  assign out_frame_word   = out_frame_r;
  assign out_address_byte = out_addr_r;
  assign out_command_byte = out_cmd_r;
  assign out_repeat_count = out_cnt_r;

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  a_bit_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_pos_r <= FRAME_BITS)
    else $error("bit position beyond frame length");

  a_full_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == EVT_FULL)) |-> (out_cnt_r == '0))
    else $error("full frame result with nonzero repeat count");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit) |=> (valid_mark_r && out_valid_r))
    else $error("result issued without a valid frame mark");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with no blocked result");

  a_repeat_needs_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (phase_r == PH_REPBURST)) |-> valid_mark_r)
    else $error("repeat burst reached without a valid frame");

endmodule
